[src/vcc_pkg.sv]
// Shared types, codes and the coin denomination table for the vending
// coin and change controller. No dependencies.
`default_nettype none

package vcc_pkg;

  localparam int STORE_DEPTH = 24;
  localparam int PROD_W      = 5;
  localparam int STOCK_W     = 4;
  localparam int AMT_W       = 9;
  localparam int COIN_W      = 8;
  localparam int CNT_W       = 4;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int DIDX_W      = 3;

  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_COIN   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PRICE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRICE_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRICE_HIGH = 2'd2;

  localparam logic [DIDX_W-1:0] DENOM_FIRST = 3'd0;
  localparam logic [DIDX_W-1:0] DENOM_LAST  = 3'd7;

  typedef enum logic [STATUS_W-1:0] {
    ST_SELECTED     = 3'd0,
    ST_OUT_OF_STOCK = 3'd1,
    ST_NO_PRODUCT   = 3'd2,
    ST_COIN_OK      = 3'd3,
    ST_COIN_REJECT  = 3'd4,
    ST_IGNORED      = 3'd5,
    ST_CHANGE       = 3'd6,
    ST_VEND_DONE    = 3'd7
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;     // capture the accepted input item
    logic eval;      // decide the item, update state, emit first result unless payment completes
    logic chg_step;  // process one change denomination
    logic vend;      // emit the vend-done result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic eval_change;  // coin completed payment: run change breakdown
    logic eval_vend;    // free product: vend result follows
    logic chg_emit;     // current denomination returns at least one coin
    logic chg_last;     // current denomination is the smallest
  } sts_t;

  // Greedy order, largest first
  function automatic logic [COIN_W-1:0] denom(input logic [DIDX_W-1:0] idx);
    logic [COIN_W-1:0] d;
    case (idx)
      3'd0:    d = 8'd200;
      3'd1:    d = 8'd100;
      3'd2:    d = 8'd50;
      3'd3:    d = 8'd20;
      3'd4:    d = 8'd10;
      3'd5:    d = 8'd5;
      3'd6:    d = 8'd2;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  function automatic logic valid_coin(input logic [COIN_W-1:0] c);
    return c inside {8'd1, 8'd2, 8'd5, 8'd10, 8'd20, 8'd50, 8'd100, 8'd200};
  endfunction

endpackage

`default_nettype wire

[src/vcc_in_if.sv]
// Input request channel: valid/ready plus the request fields.
// Depends on vcc_pkg for field widths.
`default_nettype none

interface vcc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [vcc_pkg::PROD_W-1:0]   product_index;
  logic [vcc_pkg::COIN_W-1:0]   coin_cents;

  modport source (output valid, output req_type, output product_index,
                  output coin_cents, input ready);
  modport sink   (input valid, input req_type, input product_index,
                  input coin_cents, output ready);
endinterface

`default_nettype wire

[src/vcc_out_if.sv]
// Result channel: valid/ready plus the result fields.
// Depends on vcc_pkg for field widths.
`default_nettype none

interface vcc_out_if;
  logic                           valid;
  logic                           ready;
  logic [vcc_pkg::STATUS_W-1:0]   status;
  logic [vcc_pkg::PROD_W-1:0]     product_out;
  logic [vcc_pkg::STOCK_W-1:0]    stock_left;
  logic [vcc_pkg::AMT_W-1:0]      amount_cents;
  logic [vcc_pkg::COIN_W-1:0]     change_coin_value;
  logic [vcc_pkg::CNT_W-1:0]      change_coin_count;
  logic                           last;

  modport source (output valid, output status, output product_out, output stock_left,
                  output amount_cents, output change_coin_value,
                  output change_coin_count, output last, input ready);
  modport sink   (input valid, input status, input product_out, input stock_left,
                  input amount_cents, input change_coin_value,
                  input change_coin_count, input last, output ready);
endinterface

`default_nettype wire

[src/vcc_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on vcc_pkg for widths.
`default_nettype none

interface vcc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vcc_pkg::CFG_IDX_W-1:0]    index;
  logic [vcc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/vcc_datapath.sv]
// Datapath: price registers, stock store, payment state, change breakdown
// and the output result register. Depends on vcc_pkg and vcc_out_if.
`default_nettype none

module vcc_datapath #(
  parameter int NUM_PRODUCTS  = 20,
  parameter int INITIAL_STOCK = 2
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire vcc_pkg::cmd_t                    cmd,
  output vcc_pkg::sts_t                         sts,
  input  wire logic                             in_req_type,
  input  wire logic [vcc_pkg::PROD_W-1:0]       in_product_index,
  input  wire logic [vcc_pkg::COIN_W-1:0]       in_coin_cents,
  input  wire logic                             cfg_write,
  input  wire logic [vcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vcc_pkg::CFG_DATA_W-1:0]   cfg_data,
  vcc_out_if.source                             out_ch
);

  localparam int PW = vcc_pkg::PROD_W;
  localparam int SW = vcc_pkg::STOCK_W;
  localparam int AW = vcc_pkg::AMT_W;
  localparam int CW = vcc_pkg::COIN_W;
  localparam int NW = vcc_pkg::CNT_W;
  localparam int DEPTH = vcc_pkg::STORE_DEPTH;
  localparam logic [PW:0]   NumProd   = (PW+1)'(NUM_PRODUCTS);
  localparam logic [SW-1:0] InitStock = SW'(INITIAL_STOCK);
  localparam logic [PW-1:0] DepthLim  = PW'(DEPTH);

  // latched input item
  logic          req_r;
  logic [PW-1:0] prod_r;
  logic [CW-1:0] coin_r;

  logic [vcc_pkg::CFG_DATA_W-1:0] price_r [3];
  logic [vcc_pkg::CFG_DATA_W-1:0] price_nxt [3];
  logic [SW-1:0] stock_r [DEPTH];
  logic [SW-1:0] stock_nxt [DEPTH];

  logic                        paying_r, paying_nxt;
  logic [PW-1:0]               cp_r, cp_nxt;
  logic [AW-1:0]               rem_r, rem_nxt;
  logic [CW-1:0]               left_r, left_nxt;
  logic [AW-1:0]               chg_total_r, chg_total_nxt;
  logic [vcc_pkg::DIDX_W-1:0]  didx_r, didx_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [vcc_pkg::STATUS_W-1:0] o_status_r, o_status_nxt;
  logic [PW-1:0]               o_prod_r, o_prod_nxt;
  logic [SW-1:0]               o_stock_r, o_stock_nxt;
  logic [AW-1:0]               o_amt_r, o_amt_nxt;
  logic [CW-1:0]               o_cval_r, o_cval_nxt;
  logic [NW-1:0]               o_ccnt_r, o_ccnt_nxt;
  logic                        o_last_r, o_last_nxt;

  logic          sel_req, prod_ok, coin_ok, completes, free_sel;
  logic [PW-1:0] rd_addr;
  logic [SW-1:0] stock_rd, stock_dec;
  logic [1:0]    bank;
  logic [CW-1:0] price;
  logic [AW-1:0] coin9, change9, rem_sub;
  logic          out_free;

  // eval result
  logic                         e_emit;
  logic [vcc_pkg::STATUS_W-1:0] e_status;
  logic [PW-1:0]                e_prod;
  logic [SW-1:0]                e_stock;
  logic [AW-1:0]                e_amt;
  logic                         e_last;

  // change step
  logic [CW-1:0] d;
  logic [AW-1:0] left9, two_d;
  logic          ge1, ge2;
  logic [NW-1:0] n_coins;
  logic [AW-1:0] left_sub;

  always_comb begin
    sel_req  = (req_r == vcc_pkg::REQ_SELECT);
    rd_addr  = (sel_req && !paying_r) ? prod_r : cp_r;
    stock_rd = (rd_addr < DepthLim) ? stock_r[rd_addr] : '0;
    stock_dec = (stock_rd == '0) ? '0 : stock_rd - 1'b1;
    bank  = prod_r[PW-1:3];
    price = (bank == 2'd3) ? '0 : price_r[bank][{prod_r[2:0], 3'b000} +: CW];
    prod_ok = ({1'b0, prod_r} < NumProd) && (prod_r < DepthLim);
    coin_ok = vcc_pkg::valid_coin(coin_r);
    coin9   = {1'b0, coin_r};
    change9 = coin9 - rem_r;
    rem_sub = rem_r - coin9;
    completes = !sel_req && paying_r && coin_ok && !(coin9 < rem_r);
    free_sel  = sel_req && !paying_r && prod_ok && (stock_rd != '0) && (price == '0);

    e_emit   = !completes;
    e_status = vcc_pkg::ST_IGNORED;
    e_prod   = cp_r;
    e_stock  = stock_rd;
    e_amt    = '0;
    e_last   = 1'b1;
    if (sel_req) begin
      if (paying_r) begin
        e_amt = rem_r;
      end else if (!prod_ok) begin
        e_status = vcc_pkg::ST_NO_PRODUCT;
        e_prod   = prod_r;
        e_stock  = '0;
      end else if (stock_rd == '0) begin
        e_status = vcc_pkg::ST_OUT_OF_STOCK;
        e_prod   = prod_r;
        e_stock  = '0;
        e_amt    = {1'b0, price};
      end else begin
        e_status = vcc_pkg::ST_SELECTED;
        e_prod   = prod_r;
        if (price == '0) begin
          e_stock = stock_dec;
          e_last  = 1'b0;
        end else begin
          e_amt = {1'b0, price};
        end
      end
    end else if (paying_r) begin
      if (!coin_ok) begin
        e_status = vcc_pkg::ST_COIN_REJECT;
        e_amt    = rem_r;
      end else begin
        e_status = vcc_pkg::ST_COIN_OK;
        e_amt    = rem_sub;
      end
    end

    // At most two coins of any denomination remain once larger ones are taken.
    d     = vcc_pkg::denom(didx_r);
    left9 = {1'b0, left_r};
    two_d = {d, 1'b0};
    ge2   = (left9 >= two_d);
    ge1   = (left_r >= d);
    if (ge2) begin
      n_coins  = 4'd2;
      left_sub = left9 - two_d;
    end else if (ge1) begin
      n_coins  = 4'd1;
      left_sub = left9 - {1'b0, d};
    end else begin
      n_coins  = 4'd0;
      left_sub = left9;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  assign sts.out_free    = out_free;
  assign sts.eval_change = completes;
  assign sts.eval_vend   = free_sel;
  assign sts.chg_emit    = ge1;
  assign sts.chg_last    = (didx_r == vcc_pkg::DENOM_LAST);

  always_comb begin
    price_nxt     = price_r;
    stock_nxt     = stock_r;
    paying_nxt    = paying_r;
    cp_nxt        = cp_r;
    rem_nxt       = rem_r;
    left_nxt      = left_r;
    chg_total_nxt = chg_total_r;
    didx_nxt      = didx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_status_nxt  = o_status_r;
    o_prod_nxt    = o_prod_r;
    o_stock_nxt   = o_stock_r;
    o_amt_nxt     = o_amt_r;
    o_cval_nxt    = o_cval_r;
    o_ccnt_nxt    = o_ccnt_r;
    o_last_nxt    = o_last_r;

    if (cfg_write) begin
      case (cfg_index)
        vcc_pkg::CFG_PRICE_LOW:  price_nxt[0] = cfg_data;
        vcc_pkg::CFG_PRICE_MID:  price_nxt[1] = cfg_data;
        vcc_pkg::CFG_PRICE_HIGH: price_nxt[2] = cfg_data;
        default: ;
      endcase
    end

    if (cmd.eval) begin
      if (sel_req && !paying_r && prod_ok && (stock_rd != '0)) begin
        cp_nxt = prod_r;
        if (price == '0) begin
          stock_nxt[rd_addr] = stock_dec;
          rem_nxt       = '0;
          chg_total_nxt = '0;
        end else begin
          paying_nxt = 1'b1;
          rem_nxt    = {1'b0, price};
        end
      end else if (!sel_req && paying_r && coin_ok) begin
        if (completes) begin
          rem_nxt            = '0;
          paying_nxt         = 1'b0;
          stock_nxt[rd_addr] = stock_dec;
          chg_total_nxt      = change9;
          left_nxt           = change9[CW-1:0];
          didx_nxt           = vcc_pkg::DENOM_FIRST;
        end else begin
          rem_nxt = rem_sub;
        end
      end
      if (e_emit) begin
        out_valid_nxt = 1'b1;
        o_status_nxt  = e_status;
        o_prod_nxt    = e_prod;
        o_stock_nxt   = e_stock;
        o_amt_nxt     = e_amt;
        o_cval_nxt    = '0;
        o_ccnt_nxt    = '0;
        o_last_nxt    = e_last;
      end
    end

    if (cmd.chg_step) begin
      left_nxt = left_sub[CW-1:0];
      didx_nxt = didx_r + 1'b1;
      if (ge1) begin
        out_valid_nxt = 1'b1;
        o_status_nxt  = vcc_pkg::ST_CHANGE;
        o_prod_nxt    = cp_r;
        o_stock_nxt   = stock_rd;
        o_amt_nxt     = chg_total_r;
        o_cval_nxt    = d;
        o_ccnt_nxt    = n_coins;
        o_last_nxt    = 1'b0;
      end
    end

    if (cmd.vend) begin
      out_valid_nxt = 1'b1;
      o_status_nxt  = vcc_pkg::ST_VEND_DONE;
      o_prod_nxt    = cp_r;
      o_stock_nxt   = stock_rd;
      o_amt_nxt     = chg_total_r;
      o_cval_nxt    = '0;
      o_ccnt_nxt    = '0;
      o_last_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        price_r[i] <= '0;
      end
      for (int i = 0; i < DEPTH; i++) begin
        stock_r[i] <= InitStock;
      end
      paying_r    <= 1'b0;
      cp_r        <= '0;
      rem_r       <= '0;
      didx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      price_r     <= price_nxt;
      stock_r     <= stock_nxt;
      paying_r    <= paying_nxt;
      cp_r        <= cp_nxt;
      rem_r       <= rem_nxt;
      didx_r      <= didx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_req_type;
      prod_r <= in_product_index;
      coin_r <= in_coin_cents;
    end
    left_r      <= left_nxt;
    chg_total_r <= chg_total_nxt;
    o_status_r  <= o_status_nxt;
    o_prod_r    <= o_prod_nxt;
    o_stock_r   <= o_stock_nxt;
    o_amt_r     <= o_amt_nxt;
    o_cval_r    <= o_cval_nxt;
    o_ccnt_r    <= o_ccnt_nxt;
    o_last_r    <= o_last_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = o_status_r;
  assign out_ch.product_out       = o_prod_r;
  assign out_ch.stock_left        = o_stock_r;
  assign out_ch.amount_cents      = o_amt_r;
  assign out_ch.change_coin_value = o_cval_r;
  assign out_ch.change_coin_count = o_ccnt_r;
  assign out_ch.last              = o_last_r;

endmodule

`default_nettype wire

[src/vcc_controller.sv]
// Controller state machine: sequences accept, decision, change breakdown
// and vend for one item at a time. Depends on vcc_pkg.
`default_nettype none

module vcc_controller (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire vcc_pkg::sts_t  sts,
  output vcc_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_CHANGE = 4'b0100,
    S_VEND   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.out_free) begin
          cmd.eval = 1'b1;
          if (sts.eval_change) begin
            state_nxt = S_CHANGE;
          end else if (sts.eval_vend) begin
            state_nxt = S_VEND;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CHANGE: begin
        // skip unused denominations without waiting on the output
        if (!sts.chg_emit || sts.out_free) begin
          cmd.chg_step = 1'b1;
          if (sts.chg_last) begin
            state_nxt = S_VEND;
          end
        end
      end
      S_VEND: begin
        if (sts.out_free) begin
          cmd.vend  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[src/vending_coin_and_change_controller_top.sv]
// Vending coin and change controller, top level: controller plus datapath.
// Depends on vcc_pkg, vcc_in_if, vcc_out_if, vcc_cfg_if and both submodules.
//
// Takes one request at a time. A select or a coin that does not finish a
// payment is transferred, then decided, and its result sits in an output
// register, so the next request transfers while it waits. A coin that
// finishes a payment runs the greedy change breakdown, one denomination per
// cycle over all eight, then the vend result; a free product is decided,
// then vended. Output back-pressure holds the decision step, and any later
// step that has a result due, until the output register is free.
// Configuration writes are taken every cycle; write prices only while idle.
// Stock resets to INITIAL_STOCK for every product; no clearing pass is needed.
`default_nettype none

module vending_coin_and_change_controller_top #(
  parameter int NUM_PRODUCTS  = 20,
  parameter int INITIAL_STOCK = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  vcc_in_if.sink      in_ch,
  vcc_out_if.source   out_ch,
  vcc_cfg_if.sink     cfg_ch
);

  vcc_pkg::cmd_t cmd;
  vcc_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  vcc_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vcc_datapath #(
    .NUM_PRODUCTS  (NUM_PRODUCTS),
    .INITIAL_STOCK (INITIAL_STOCK)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_ch.req_type),
    .in_product_index (in_ch.product_index),
    .in_coin_cents    (in_ch.coin_cents),
    .cfg_write        (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_ch           (out_ch)
  );

endmodule

`default_nettype wire
